// File: rtl/button_debounce_long_press_assert.svh
// Assertion macros shared by the button debounce RTL.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication.
`define BDLP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bdlp_pkg.sv
package bdlp_pkg;

   // Width of the internal time stamps; differences wrap modulo 2^TIME_BITS.
   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;
   localparam int CFG_BITS  = 16;

   localparam int NUM_BUTTONS = 3;
   localparam int BTN_TEAM_ONE = 0;
   localparam int BTN_TEAM_TWO = 1;
   localparam int BTN_UNDO     = 2;

   // Configuration register map
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE_MS   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_PRESS_MS = 8'd1;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd3000;

   typedef logic [TIME_BITS-1:0] stamp_type;

   // One button sample; level 0 means pressed
   typedef struct packed {
      logic [NOW_BITS-1:0]    now_ms;
      logic [NUM_BUTTONS-1:0] levels;
   } sample_type;

   typedef struct packed {
      logic team_one_event;
      logic team_two_event;
      logic undo_short;
      logic reset_long;
   } flags_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] long_press_ms;
   } cfg_type;

endpackage

// File: rtl/bdlp_req_bus.sv
interface bdlp_req_bus;
   logic                          valid;
   logic                          ready;
   logic [bdlp_pkg::NOW_BITS-1:0] now_ms;
   logic                          team_one_level;
   logic                          team_two_level;
   logic                          undo_level;

   modport source (output valid, now_ms, team_one_level, team_two_level, undo_level,
                   input ready);
   modport sink   (input valid, now_ms, team_one_level, team_two_level, undo_level,
                   output ready);
endinterface

// File: rtl/bdlp_rsp_bus.sv
interface bdlp_rsp_bus;
   logic valid;
   logic ready;
   logic team_one_event;
   logic team_two_event;
   logic undo_short;
   logic reset_long;

   modport source (output valid, team_one_event, team_two_event, undo_short, reset_long,
                   input ready);
   modport sink   (input valid, team_one_event, team_two_event, undo_short, reset_long,
                   output ready);
endinterface

// File: rtl/bdlp_csr_bus.sv
interface bdlp_csr_bus;
   logic                                valid;
   logic                                ready;
   logic [bdlp_pkg::CSR_INDEX_BITS-1:0] index;
   logic [bdlp_pkg::CFG_BITS-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bdlp_core.sv
`include "button_debounce_long_press_assert.svh"

// Per-button debounce state and event decode. Flags are combinational from
// the registered sample; state advances on step.
module bdlp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  bdlp_pkg::sample_type sample_i,
   input  bdlp_pkg::cfg_type    cfg_i,
   output bdlp_pkg::flags_type  flags_o
);

   logic [bdlp_pkg::NUM_BUTTONS-1:0] raw_prev_ff, raw_prev_in;
   logic [bdlp_pkg::NUM_BUTTONS-1:0] stable_ff, stable_in;
   bdlp_pkg::stamp_type              change_time_ff [bdlp_pkg::NUM_BUTTONS];
   bdlp_pkg::stamp_type              change_time_in [bdlp_pkg::NUM_BUTTONS];
   bdlp_pkg::stamp_type              press_start_ff, press_start_in;
   logic                             long_rep_ff, long_rep_in;

   bdlp_pkg::stamp_type              now;
   bdlp_pkg::stamp_type              debounce;
   bdlp_pkg::stamp_type              long_press;
   logic [bdlp_pkg::NUM_BUTTONS-1:0] raw;
   logic [bdlp_pkg::NUM_BUTTONS-1:0] changed;
   logic [bdlp_pkg::NUM_BUTTONS-1:0] settled;
   logic                             press_new;
   logic                             long_rep_cur;
   logic                             long_hit;
   logic                             undo_hit;

   assign now        = bdlp_pkg::stamp_type'(sample_i.now_ms);
   assign debounce   = bdlp_pkg::stamp_type'(cfg_i.debounce_ms);
   assign long_press = bdlp_pkg::stamp_type'(cfg_i.long_press_ms);
   assign raw        = sample_i.levels;

   // Raw change tracking; a button is settled once its level outlived the window
   always_comb begin
      for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
         changed[b]        = raw[b] != raw_prev_ff[b];
         change_time_in[b] = changed[b] ? now : change_time_ff[b];
         settled[b]        = !changed[b] && ((now - change_time_ff[b]) > debounce);
      end
      raw_prev_in = raw;
   end

   // Undo button: press start, long hold and short release
   always_comb begin
      press_new      = !raw[bdlp_pkg::BTN_UNDO] && stable_ff[bdlp_pkg::BTN_UNDO];
      press_start_in = press_start_ff;
      long_rep_cur   = long_rep_ff;
      if (settled[bdlp_pkg::BTN_UNDO] && press_new) begin
         press_start_in = now;
         long_rep_cur   = 1'b0;
      end
      long_hit = settled[bdlp_pkg::BTN_UNDO] && !raw[bdlp_pkg::BTN_UNDO] && !long_rep_cur
                 && ((now - press_start_in) >= long_press);
      undo_hit = settled[bdlp_pkg::BTN_UNDO] && raw[bdlp_pkg::BTN_UNDO]
                 && !stable_ff[bdlp_pkg::BTN_UNDO] && !long_rep_ff;
      long_rep_in = long_hit ? 1'b1 : long_rep_cur;
   end

   // Stable levels follow the raw level once settled
   always_comb begin
      for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
         stable_in[b] = settled[b] ? raw[b] : stable_ff[b];
      end
   end

   always_comb begin
      flags_o.team_one_event = settled[bdlp_pkg::BTN_TEAM_ONE]
                               && stable_ff[bdlp_pkg::BTN_TEAM_ONE]
                               && !raw[bdlp_pkg::BTN_TEAM_ONE];
      flags_o.team_two_event = settled[bdlp_pkg::BTN_TEAM_TWO]
                               && stable_ff[bdlp_pkg::BTN_TEAM_TWO]
                               && !raw[bdlp_pkg::BTN_TEAM_TWO];
      flags_o.undo_short     = undo_hit;
      flags_o.reset_long     = long_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff    <= '1;
         stable_ff      <= '1;
         press_start_ff <= '0;
         long_rep_ff    <= 1'b0;
         for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
            change_time_ff[b] <= '0;
         end
      end else if (step) begin
         raw_prev_ff    <= raw_prev_in;
         stable_ff      <= stable_in;
         press_start_ff <= press_start_in;
         long_rep_ff    <= long_rep_in;
         for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
            change_time_ff[b] <= change_time_in[b];
         end
      end
   end

   `BDLP_ASSERT_NEXT(a_long_marks_hold, step && flags_o.reset_long, long_rep_ff,
                     "long report not recorded for the hold")
   `BDLP_ASSERT_NOW(a_team_one_pressed, step && flags_o.team_one_event,
                    !sample_i.levels[bdlp_pkg::BTN_TEAM_ONE],
                    "team one event without pressed level")
   `BDLP_ASSERT_NEXT(a_long_once, step && long_rep_ff && !press_new,
                     !flags_o.reset_long || !step,
                     "second long report in one hold")

endmodule

// File: rtl/button_debounce_long_press.sv
// Channel  Dir  Payload                                            Role
// req      in   now_ms, team_one_level, team_two_level, undo_level  one sample
// rsp      out  team_one_event, team_two_event, undo_short,         one result
//               reset_long                                          per sample
// csr      in   index, data                                         register write
//
// Two register stages: the sample register, then the result register; a sample taken
// on req is decoded into the result register, which drives rsp.
// One sample per cycle sustained while rsp is ready; the decode between the stages is a few
// subtractions and compares on the time stamps.
// Synchronous reset clears all button state and loads the default settings.
// A stalled rsp holds its result; req keeps taking items until both stages are full.
`include "button_debounce_long_press_assert.svh"

module button_debounce_long_press (
   input logic          clock,
   input logic          reset,
   bdlp_req_bus.sink    req_port,
   bdlp_rsp_bus.source  rsp_port,
   bdlp_csr_bus.sink    csr_port
);

   bdlp_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   bdlp_pkg::sample_type sample_ff;
   logic                 out_valid_ff, out_valid_in;
   bdlp_pkg::flags_type  flags_ff;
   bdlp_pkg::flags_type  flags;
   logic                 out_load;
   logic                 req_take;

   // Configuration writes; unknown indexes are dropped
   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         priority if (csr_port.index == bdlp_pkg::REG_DEBOUNCE_MS) begin
            cfg_in.debounce_ms = csr_port.data;
         end else if (csr_port.index == bdlp_pkg::REG_LONG_PRESS_MS) begin
            cfg_in.long_press_ms = csr_port.data;
         end else begin
            cfg_in = cfg_ff;
         end
      end
   end

   // Two-stage handshake
   assign out_load       = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || out_load;
   assign req_take       = req_port.valid && req_port.ready;
   assign in_valid_in    = req_take ? 1'b1 : (out_load ? 1'b0 : in_valid_ff);
   assign out_valid_in   = out_load ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);

   bdlp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (out_load),
      .sample_i (sample_ff),
      .cfg_i    (cfg_ff),
      .flags_o  (flags)
   );

   // Control and settings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= bdlp_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= bdlp_pkg::LONG_PRESS_RESET;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff.now_ms <= req_port.now_ms;
         sample_ff.levels <= {req_port.undo_level, req_port.team_two_level,
                              req_port.team_one_level};
      end
      if (out_load) begin
         flags_ff <= flags;
      end
   end

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.team_one_event = flags_ff.team_one_event;
   assign rsp_port.team_two_event = flags_ff.team_two_event;
   assign rsp_port.undo_short     = flags_ff.undo_short;
   assign rsp_port.reset_long     = flags_ff.reset_long;

   `BDLP_ASSERT_NOW(a_undo_excl, out_valid_ff,
                    !(flags_ff.undo_short && flags_ff.reset_long),
                    "short and long undo in one item")
   `BDLP_ASSERT_NOW(a_full_blocks, in_valid_ff && out_valid_ff && !rsp_port.ready,
                    !req_port.ready, "item taken while both stages full")
   `BDLP_ASSERT_NEXT(a_load_shows, out_load, out_valid_ff,
                     "decoded item not presented")

endmodule
